/* hw/rtl/spc_pkg.sv */
// shared types and constants of the scan point curvature block
package spc_pkg;

   localparam int CURV_BITS = 49;
   localparam logic [CURV_BITS-1:0] CURV_MAX = {CURV_BITS{1'b1}};

   // magnitudes above this limit always saturate the square
   localparam int SQ_IN_BITS = 26;
   localparam longint unsigned SQ_LIMIT = 64'd33554432;

   typedef struct packed {
      logic curv_ok;
      logic eos;
   } spc_tag_type;

endpackage

/* hw/rtl/spc_cell.sv */
// one window cell: holds a point and a running partial sum per axis
module spc_cell #(
   parameter int COORD_BITS = 20,
   parameter int SUM_BITS   = 24
) (
   input  logic                         clock,
   input  logic                         shift,
   input  logic signed [COORD_BITS-1:0] new_p    [3],
   input  logic signed [COORD_BITS-1:0] left_p   [3],
   input  logic signed [SUM_BITS-1:0]   left_sum [3],
   output logic signed [COORD_BITS-1:0] cell_p   [3],
   output logic signed [SUM_BITS-1:0]   cell_sum [3]
);

   logic signed [COORD_BITS-1:0] point_ff [3];
   logic signed [SUM_BITS-1:0]   sum_ff   [3];
   logic signed [SUM_BITS-1:0]   sum_in   [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sum_in[a] = left_sum[a] + SUM_BITS'(new_p[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         for (int a = 0; a < 3; a++) begin
            point_ff[a] <= left_p[a];
            sum_ff[a]   <= sum_in[a];
         end
      end
   end

   assign cell_p   = point_ff;
   assign cell_sum = sum_ff;

endmodule

/* hw/rtl/spc_chain.sv */
// row of window cells with the next centre point and next window sum
module spc_chain #(
   parameter int HALF_WINDOW = 5,
   parameter int COORD_BITS  = 20,
   parameter int SUM_BITS    = 24
) (
   input  logic                         clock,
   input  logic                         shift,
   input  logic signed [COORD_BITS-1:0] new_p       [3],
   output logic signed [COORD_BITS-1:0] centre_next [3],
   output logic signed [SUM_BITS-1:0]   sum_next    [3]
);

   localparam int CELLS = 2 * HALF_WINDOW;

   logic signed [COORD_BITS-1:0] point [CELLS][3];
   logic signed [SUM_BITS-1:0]   psum  [CELLS][3];
   logic signed [SUM_BITS-1:0]   zero_sum [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         zero_sum[a] = '0;
      end
   end

   for (genvar j = 0; j < CELLS; j++) begin : g_cell
      if (j == 0) begin : g_head
         spc_cell #(.COORD_BITS(COORD_BITS), .SUM_BITS(SUM_BITS)) u_cell (
            .clock    (clock),
            .shift    (shift),
            .new_p    (new_p),
            .left_p   (new_p),
            .left_sum (zero_sum),
            .cell_p   (point[j]),
            .cell_sum (psum[j])
         );
      end else begin : g_body
         spc_cell #(.COORD_BITS(COORD_BITS), .SUM_BITS(SUM_BITS)) u_cell (
            .clock    (clock),
            .shift    (shift),
            .new_p    (new_p),
            .left_p   (point[j-1]),
            .left_sum (psum[j-1]),
            .cell_p   (point[j]),
            .cell_sum (psum[j])
         );
      end
   end

   // after the shift the centre holds today's cell HALF_WINDOW-1
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         centre_next[a] = point[HALF_WINDOW-1][a];
         sum_next[a]    = psum[CELLS-1][a] + SUM_BITS'(new_p[a]);
      end
   end

endmodule

/* hw/rtl/spc_curv.sv */
// curvature pipeline: difference, saturating square, sum and output register
module spc_curv #(
   parameter int HALF_WINDOW = 5,
   parameter int COORD_BITS  = 20,
   parameter int SUM_BITS    = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic signed [SUM_BITS-1:0]          in_sum    [3],
   input  logic signed [COORD_BITS-1:0]        in_centre [3],
   input  spc_pkg::spc_tag_type                in_tag,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [COORD_BITS-1:0]        rsp_out_x,
   output logic signed [COORD_BITS-1:0]        rsp_out_y,
   output logic signed [COORD_BITS-1:0]        rsp_out_z,
   output logic [spc_pkg::CURV_BITS-1:0]       rsp_curvature,
   output logic                                rsp_curvature_valid,
   output logic                                rsp_end_of_scan
);
   import spc_pkg::*;

   localparam int DIFF_BITS = COORD_BITS + $clog2(2 * HALF_WINDOW + 1) + 2;
   localparam int ABS_BITS  = (DIFF_BITS > SQ_IN_BITS + 1) ? DIFF_BITS : SQ_IN_BITS + 1;
   localparam int SQ_BITS   = 2 * SQ_IN_BITS;
   localparam int TOT_BITS  = CURV_BITS + 2;
   localparam logic signed [DIFF_BITS-1:0] WIN_LEN_S = DIFF_BITS'(2 * HALF_WINDOW + 1);
   localparam logic [ABS_BITS-1:0] ABS_LIMIT = ABS_BITS'(SQ_LIMIT);

   logic                         s1_v_ff, s2_v_ff, s3_v_ff, o_v_ff;
   logic                         s2_ready, s3_ready, o_ready;
   spc_tag_type                  s1_tag_ff, s2_tag_ff, s3_tag_ff, o_tag_ff;
   logic signed [SUM_BITS-1:0]   s1_sum_ff [3];
   logic signed [COORD_BITS-1:0] s1_cen_ff [3], s2_cen_ff [3], s3_cen_ff [3], o_cen_ff [3];
   logic signed [DIFF_BITS-1:0]  s2_d_ff [3], d_in [3];
   logic [CURV_BITS-1:0]         s3_sq_ff [3], sq_in [3];
   logic [ABS_BITS-1:0]          mag [3];
   logic [SQ_BITS-1:0]           sq_full [3];
   logic [TOT_BITS-1:0]          total;
   logic [CURV_BITS-1:0]         o_curv_ff, curv_in;

   assign o_ready  = !o_v_ff || !rsp_stall;
   assign s3_ready = !s3_v_ff || o_ready;
   assign s2_ready = !s2_v_ff || s3_ready;
   assign in_ready = !s1_v_ff || s2_ready;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         // sum of all points minus window length times centre
         d_in[a] = DIFF_BITS'(s1_sum_ff[a]) - DIFF_BITS'(s1_cen_ff[a]) * WIN_LEN_S;
         mag[a]  = s2_d_ff[a][DIFF_BITS-1] ? ABS_BITS'(-s2_d_ff[a]) : ABS_BITS'(s2_d_ff[a]);
         sq_full[a] = SQ_BITS'(mag[a][SQ_IN_BITS-1:0]) * SQ_BITS'(mag[a][SQ_IN_BITS-1:0]);
         if (mag[a] > ABS_LIMIT || sq_full[a] > SQ_BITS'(CURV_MAX)) begin
            sq_in[a] = CURV_MAX;
         end else begin
            sq_in[a] = sq_full[a][CURV_BITS-1:0];
         end
      end
      total = TOT_BITS'(s3_sq_ff[0]) + TOT_BITS'(s3_sq_ff[1]) + TOT_BITS'(s3_sq_ff[2]);
      if (!s3_tag_ff.curv_ok) begin
         curv_in = '0;
      end else if (total > TOT_BITS'(CURV_MAX)) begin
         curv_in = CURV_MAX;
      end else begin
         curv_in = total[CURV_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         o_v_ff  <= 1'b0;
      end else begin
         if (in_ready) begin
            s1_v_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_v_ff <= s1_v_ff;
         end
         if (s3_ready) begin
            s3_v_ff <= s2_v_ff;
         end
         if (o_ready) begin
            o_v_ff <= s3_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         s1_sum_ff <= in_sum;
         s1_cen_ff <= in_centre;
         s1_tag_ff <= in_tag;
      end
      if (s2_ready && s1_v_ff) begin
         s2_d_ff   <= d_in;
         s2_cen_ff <= s1_cen_ff;
         s2_tag_ff <= s1_tag_ff;
      end
      if (s3_ready && s2_v_ff) begin
         s3_sq_ff  <= sq_in;
         s3_cen_ff <= s2_cen_ff;
         s3_tag_ff <= s2_tag_ff;
      end
      if (o_ready && s3_v_ff) begin
         o_curv_ff <= curv_in;
         o_cen_ff  <= s3_cen_ff;
         o_tag_ff  <= s3_tag_ff;
      end
   end

   assign rsp_valid           = o_v_ff;
   assign rsp_out_x           = o_cen_ff[0];
   assign rsp_out_y           = o_cen_ff[1];
   assign rsp_out_z           = o_cen_ff[2];
   assign rsp_curvature       = o_curv_ff;
   assign rsp_curvature_valid = o_tag_ff.curv_ok;
   assign rsp_end_of_scan     = o_tag_ff.eos;

endmodule

/* hw/rtl/scan_point_curvature.sv */
// top level of the streaming lidar point curvature block
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   req     | in        | req_valid/req_stall| point_x, point_y, point_z, last_in_scan
//   rsp     | out       | rsp_valid/rsp_stall| out_x/y/z, curvature, curvature_valid,
//           |           |                    | end_of_scan
//
// one request per cycle while a scan streams in and req_stall is low; each point passes
// the input, difference, square and output registers after the request that places it in the window centre
// the request marked last_in_scan is followed by HALF_WINDOW flush steps in which the
// window row shifts without new requests; the flush length is set by HALF_WINDOW, half
// the depth of the cell row
// a synchronous reset clears the fill count, the flush sequencer and the pipeline valids;
// window contents stay undefined until written by the scan
// rsp_stall holds the result pipeline; requests keep flowing until every stage is full
module scan_point_curvature #(
   parameter int HALF_WINDOW = 5,
   parameter int COORD_BITS  = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_point_x,
   input  logic signed [COORD_BITS-1:0]  req_point_y,
   input  logic signed [COORD_BITS-1:0]  req_point_z,
   input  logic                          req_last_in_scan,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS-1:0]  rsp_out_x,
   output logic signed [COORD_BITS-1:0]  rsp_out_y,
   output logic signed [COORD_BITS-1:0]  rsp_out_z,
   output logic [spc_pkg::CURV_BITS-1:0] rsp_curvature,
   output logic                          rsp_curvature_valid,
   output logic                          rsp_end_of_scan
);
   import spc_pkg::*;

   localparam int SUM_BITS = COORD_BITS + $clog2(2 * HALF_WINDOW + 1);
   localparam int FILL_BITS = $clog2(2 * HALF_WINDOW + 1);
   localparam int STEP_BITS = $clog2(HALF_WINDOW + 1);
   localparam logic [FILL_BITS-1:0] FILL_HALF = FILL_BITS'(HALF_WINDOW);
   localparam logic [FILL_BITS-1:0] FILL_FULL = FILL_BITS'(2 * HALF_WINDOW);
   localparam logic [STEP_BITS-1:0] STEP_HALF = STEP_BITS'(HALF_WINDOW);
   localparam logic [STEP_BITS-1:0] STEP_ONE  = STEP_BITS'(1);

   // fill count of the current scan, saturating at a full window
   logic [FILL_BITS-1:0] fill_ff, fill_in;
   // flush sequencer: steps left and how many of the last steps emit
   logic                 flushing_ff, flushing_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [STEP_BITS-1:0] pend_ff, pend_in;

   logic                 pipe_ready;
   logic                 accept;
   logic                 flush_step;
   logic                 shift;
   logic                 emit;
   spc_tag_type          tag;

   logic signed [COORD_BITS-1:0] new_p       [3];
   logic signed [COORD_BITS-1:0] centre_next [3];
   logic signed [SUM_BITS-1:0]   sum_next    [3];

   assign new_p[0] = req_point_x;
   assign new_p[1] = req_point_y;
   assign new_p[2] = req_point_z;

   // no requests while the tail drains
   assign req_stall  = flushing_ff || !pipe_ready;
   assign accept     = req_valid && !req_stall;
   assign flush_step = flushing_ff && pipe_ready;
   assign shift      = accept || flush_step;

   always_comb begin
      fill_in     = fill_ff;
      flushing_in = flushing_ff;
      step_in     = step_ff;
      pend_in     = pend_ff;
      emit        = 1'b0;
      tag         = '0;
      if (accept) begin
         // the point half a window back reaches the centre
         emit        = fill_ff >= FILL_HALF;
         tag.curv_ok = fill_ff >= FILL_FULL;
         if (req_last_in_scan) begin
            fill_in     = '0;
            flushing_in = 1'b1;
            step_in     = STEP_HALF;
            // points still waiting behind the centre, the newest included
            if (fill_ff >= FILL_HALF) begin
               pend_in = STEP_HALF;
            end else begin
               pend_in = STEP_BITS'(fill_ff) + STEP_ONE;
            end
         end else if (fill_ff < FILL_FULL) begin
            fill_in = fill_ff + FILL_BITS'(1);
         end
      end else if (flush_step) begin
         // short scans first shift their points up to the centre silently
         emit    = step_ff <= pend_ff;
         tag.eos = step_ff == STEP_ONE;
         step_in = step_ff - STEP_ONE;
         if (step_ff == STEP_ONE) begin
            flushing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         flushing_ff <= 1'b0;
         step_ff     <= '0;
         pend_ff     <= '0;
      end else begin
         fill_ff     <= fill_in;
         flushing_ff <= flushing_in;
         step_ff     <= step_in;
         pend_ff     <= pend_in;
      end
   end

   // window row with running sums
   spc_chain #(
      .HALF_WINDOW (HALF_WINDOW),
      .COORD_BITS  (COORD_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_chain (
      .clock       (clock),
      .shift       (shift),
      .new_p       (new_p),
      .centre_next (centre_next),
      .sum_next    (sum_next)
   );

   // difference, squares and output register
   spc_curv #(
      .HALF_WINDOW (HALF_WINDOW),
      .COORD_BITS  (COORD_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_curv (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (shift && emit),
      .in_ready            (pipe_ready),
      .in_sum              (sum_next),
      .in_centre           (centre_next),
      .in_tag              (tag),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_out_x           (rsp_out_x),
      .rsp_out_y           (rsp_out_y),
      .rsp_out_z           (rsp_out_z),
      .rsp_curvature       (rsp_curvature),
      .rsp_curvature_valid (rsp_curvature_valid),
      .rsp_end_of_scan     (rsp_end_of_scan)
   );

endmodule

/* hw/rtl/spc_checker.sv */
// port level checks of the scan point curvature block and their binding
module spc_checker #(
   parameter int COORD_BITS = 20
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          req_last_in_scan,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [COORD_BITS-1:0]  rsp_out_x,
   input logic [spc_pkg::CURV_BITS-1:0] rsp_curvature,
   input logic                          rsp_curvature_valid,
   input logic                          rsp_end_of_scan
);

   // a stalled response stays offered with the same x coordinate
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x))
      else $error("stalled response dropped or changed");

   // points without full neighbourhood carry zero curvature
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_curvature_valid |-> rsp_curvature == '0)
      else $error("invalid point with nonzero curvature");

   // the last point of a scan never has a full neighbourhood
   a_eos_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_scan |-> !rsp_curvature_valid)
      else $error("end of scan marked with valid curvature");

   // the tail flush holds off requests right after the last point
   a_flush_stall: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_in_scan |=> req_stall)
      else $error("request taken during tail flush");

endmodule

bind scan_point_curvature spc_checker #(.COORD_BITS(COORD_BITS)) u_spc_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_last_in_scan    (req_last_in_scan),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_out_x           (rsp_out_x),
   .rsp_curvature       (rsp_curvature),
   .rsp_curvature_valid (rsp_curvature_valid),
   .rsp_end_of_scan     (rsp_end_of_scan)
);
